/* hw/rtl/template_mismatch_search_top_assert.svh */
// Assertion macros for the template mismatch search block.
`ifndef TEMPLATE_MISMATCH_SEARCH_TOP_ASSERT_SVH
`define TEMPLATE_MISMATCH_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define TMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tms_pkg.sv */
// Types and constants shared by the template mismatch search block.
package tms_pkg;

	localparam int MAX_WIDTH  = 32;
	localparam int MAX_HEIGHT = 32;
	localparam int MAX_SHIFT  = 4;

	localparam int COORD_W  = 5;
	localparam int ADDR_W   = 2 * COORD_W;
	localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
	localparam int SIZE_W   = 6;
	localparam int SHIFT_W  = $clog2(MAX_SHIFT + 1);
	localparam int CNT_W    = 11;
	localparam int PIX_W    = 32;
	localparam int PB_W     = 3;
	localparam int STATUS_W = 2;
	localparam int CMD_W    = 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [PIX_W-1:0] MASK_24   = 32'h00FF_FFFF;
	localparam logic [PIX_W-1:0] MASK_32   = 32'hFFFF_FFFF;
	localparam logic [PIX_W-1:0] BKG_RESET = 32'hFFFF_FFFF;
	localparam logic [PB_W-1:0]  PB_RGB    = 3'd3;
	localparam logic [PB_W-1:0]  PB_RGBA   = 3'd4;
	localparam logic [CNT_W-1:0] MAX_COUNT = 11'd1024;

	localparam logic REG_BACKGROUND  = 1'b0;
	localparam logic REG_PIXEL_BYTES = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPARE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_SHAPE = 2'd1,
		STATUS_PIXEL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

/* hw/rtl/template_mismatch_search_top.sv */
// Load: one cycle per pixel transfer, busy stays low, so loads run back to back.
// Compare with an error or an empty overlap: done in the cycle after the transfer, busy stays low.
// Compare otherwise: busy while scanning shifts 0..dx by 0..dy over rows by cols pixels, then draining;
// done then rises with busy low; one pixel pair per cycle from each image memory read port.
// Reset: control idle, result 0, background all ones, 4 bytes per pixel; images undefined.
// done is a one-cycle strobe; the receiver cannot stall it.
`include "template_mismatch_search_top_assert.svh"

module template_mismatch_search_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tms_pkg::PADDR_W-1:0]     paddr,
	input  logic [tms_pkg::PDATA_W-1:0]     pwdata,
	output logic [tms_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            start,
	output logic                            busy,
	input  logic [tms_pkg::CMD_W-1:0]       command,
	input  logic [tms_pkg::COORD_W-1:0]     row,
	input  logic [tms_pkg::COORD_W-1:0]     col,
	input  logic [tms_pkg::PIX_W-1:0]       pixel,
	input  logic [tms_pkg::SIZE_W-1:0]      a_width,
	input  logic [tms_pkg::SIZE_W-1:0]      a_height,
	input  logic [tms_pkg::SIZE_W-1:0]      b_width,
	input  logic [tms_pkg::SIZE_W-1:0]      b_height,
	output logic                            done,
	output logic [tms_pkg::STATUS_W-1:0]    status,
	output logic [tms_pkg::CNT_W-1:0]       min_mismatch
);
	import tms_pkg::*;

	logic [PIX_W-1:0] mem_a [DEPTH];
	logic [PIX_W-1:0] mem_b [DEPTH];
	logic [PIX_W-1:0] rd_a_s1;
	logic [PIX_W-1:0] rd_b_s1;

	logic [PIX_W-1:0] bkg_q;
	logic [PB_W-1:0]  pb_q;

	state_t state_q, state_d;
	logic   issue;
	logic   accept;

	logic               swap_q;
	logic [SHIFT_W-1:0] dx_q, dy_q, ox_q, oy_q;
	logic [COORD_W-1:0] cols_m1_q, rows_m1_q, c_q, r_q;

	logic valid_s1, last_pix_s1, last_all_s1;
	logic [CNT_W-1:0] count_q, best_q;
	logic             have_q;

	logic             done_q;
	status_t          status_q;
	logic [CNT_W-1:0] result_q;

	logic [SIZE_W-1:0] ow, oh, iw, ih, dx, dy, cols, rows;
	logic              oversize, crossed, swap, shift_err, pix_err, empty;
	status_t           setup_status;

	logic               last_c, last_r, last_x, last_y, last_pix, last_all;
	logic [COORD_W:0]   orow_sum, ocol_sum;
	logic [ADDR_W-1:0]  inner_addr, outer_addr, raddr_a, raddr_b;

	logic [PIX_W-1:0] mask, bkg_m, opx, ipx;
	logic             hit;
	logic [CNT_W-1:0] n_sum, new_best;

	assign pready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkg_q <= BKG_RESET;
			pb_q  <= PB_RGBA;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_BACKGROUND) begin
				bkg_q <= pwdata;
			end else begin
				pb_q <= pwdata[PB_W-1:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BACKGROUND:  prdata = bkg_q;
			REG_PIXEL_BYTES: prdata = {{(PDATA_W-PB_W){1'b0}}, pb_q};
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		oversize = (a_width > SIZE_W'(MAX_WIDTH)) || (b_width > SIZE_W'(MAX_WIDTH)) ||
			(a_height > SIZE_W'(MAX_HEIGHT)) || (b_height > SIZE_W'(MAX_HEIGHT));
		crossed = ((a_width > b_width) && (a_height < b_height)) ||
			((a_width < b_width) && (a_height > b_height));
		swap = (a_width < b_width) && (a_height < b_height);
		ow = swap ? b_width  : a_width;
		oh = swap ? b_height : a_height;
		iw = swap ? a_width  : b_width;
		ih = swap ? a_height : b_height;
		dx = (ow > iw) ? ow - iw : '0;
		dy = (oh > ih) ? oh - ih : '0;
		shift_err = (dx > SIZE_W'(MAX_SHIFT)) || (dy > SIZE_W'(MAX_SHIFT));
		pix_err = !((pb_q == PB_RGB) || (pb_q == PB_RGBA));
		cols = (iw < ow) ? iw : ow;
		rows = (ih < oh) ? ih : oh;
		empty = (cols == '0) || (rows == '0);
		if (oversize || crossed || shift_err) begin
			setup_status = STATUS_SHAPE;
		end else if (pix_err) begin
			setup_status = STATUS_PIXEL;
		end else if (ih == '0) begin
			setup_status = STATUS_SHAPE;
		end else begin
			setup_status = STATUS_OK;
		end
	end

	always_comb begin
		last_c   = (c_q == cols_m1_q);
		last_r   = (r_q == rows_m1_q);
		last_x   = (ox_q == dx_q);
		last_y   = (oy_q == dy_q);
		last_pix = last_c && last_r;
		last_all = last_pix && last_x && last_y;
		orow_sum = {1'b0, r_q} + {{(COORD_W+1-SHIFT_W){1'b0}}, oy_q};
		ocol_sum = {1'b0, c_q} + {{(COORD_W+1-SHIFT_W){1'b0}}, ox_q};
		inner_addr = {r_q, c_q};
		outer_addr = {orow_sum[COORD_W-1:0], ocol_sum[COORD_W-1:0]};
		raddr_a = swap_q ? inner_addr : outer_addr;
		raddr_b = swap_q ? outer_addr : inner_addr;
	end

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_LOAD_A)) begin
			mem_a[{row, col}] <= pixel;
		end
		rd_a_s1 <= mem_a[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_LOAD_B)) begin
			mem_b[{row, col}] <= pixel;
		end
		rd_b_s1 <= mem_b[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (command == CMD_COMPARE) &&
						(setup_status == STATUS_OK) && !empty) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (last_all) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (valid_s1 && last_all_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q    <= 1'b0;
			dx_q      <= '0;
			dy_q      <= '0;
			ox_q      <= '0;
			oy_q      <= '0;
			cols_m1_q <= '0;
			rows_m1_q <= '0;
			c_q       <= '0;
			r_q       <= '0;
		end else if (state_q == ST_IDLE) begin
			swap_q    <= swap;
			dx_q      <= dx[SHIFT_W-1:0];
			dy_q      <= dy[SHIFT_W-1:0];
			ox_q      <= '0;
			oy_q      <= '0;
			cols_m1_q <= COORD_W'(cols - SIZE_W'(1));
			rows_m1_q <= COORD_W'(rows - SIZE_W'(1));
			c_q       <= '0;
			r_q       <= '0;
		end else if (issue) begin
			c_q <= last_c ? '0 : c_q + COORD_W'(1);
			if (last_c) begin
				r_q <= last_r ? '0 : r_q + COORD_W'(1);
			end
			if (last_pix) begin
				ox_q <= last_x ? '0 : ox_q + SHIFT_W'(1);
				if (last_x) begin
					oy_q <= last_y ? '0 : oy_q + SHIFT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_pix_s1 <= 1'b0;
			last_all_s1 <= 1'b0;
		end else begin
			valid_s1    <= issue;
			last_pix_s1 <= last_pix;
			last_all_s1 <= last_all;
		end
	end

	always_comb begin
		mask     = (pb_q == PB_RGB) ? MASK_24 : MASK_32;
		bkg_m    = bkg_q & mask;
		opx      = (swap_q ? rd_b_s1 : rd_a_s1) & mask;
		ipx      = (swap_q ? rd_a_s1 : rd_b_s1) & mask;
		hit      = (opx != ipx) && ((opx == bkg_m) || (ipx == bkg_m));
		n_sum    = count_q + {{(CNT_W-1){1'b0}}, hit};
		new_best = (!have_q || (n_sum < best_q)) ? n_sum : best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			best_q   <= '0;
			have_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= STATUS_OK;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept && (command == CMD_COMPARE)) begin
				count_q <= '0;
				have_q  <= 1'b0;
				if ((setup_status != STATUS_OK) || empty) begin
					done_q   <= 1'b1;
					status_q <= setup_status;
					result_q <= '0;
				end
			end else if (valid_s1) begin
				if (last_pix_s1) begin
					count_q <= '0;
					best_q  <= new_best;
					have_q  <= 1'b1;
				end else begin
					count_q <= n_sum;
				end
				if (last_all_s1) begin
					done_q   <= 1'b1;
					status_q <= STATUS_OK;
					result_q <= new_best;
					have_q   <= 1'b0;
				end
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign min_mismatch = result_q;

	`TMS_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`TMS_ASSERT_NOW(a_pipe_busy, clk, arst_n, valid_s1, busy, "read data outside a scan")
	`TMS_ASSERT_NOW(a_err_zero, clk, arst_n, done && (status != STATUS_OK), min_mismatch == '0, "error result with nonzero count")
	`TMS_ASSERT_NOW(a_count_range, clk, arst_n, done, min_mismatch <= MAX_COUNT, "count above pixel total")
	`TMS_ASSERT_NEXT(a_scan_start, clk, arst_n, accept && (command == CMD_COMPARE) && (setup_status == STATUS_OK) && !empty, busy && !done, "scan did not start")

endmodule

/* tb/sv/tb_template_mismatch_search_top.sv */
// Self-checking testbench for template_mismatch_search_top: image loads, compares and register writes.
module tb_template_mismatch_search_top;
	import tms_pkg::*;

	localparam int LIMIT_CYCLES  = 5_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int REPORT_LIMIT  = 10;
	localparam int FRAME_SIZE    = 16;

	typedef struct {
		cmd_t              cmd;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   pixel;
		logic [SIZE_W-1:0]  aw;
		logic [SIZE_W-1:0]  ah;
		logic [SIZE_W-1:0]  bw;
		logic [SIZE_W-1:0]  bh;
	} work_item_t;

	typedef struct {
		status_t          st;
		logic [CNT_W-1:0] cnt;
	} verdict_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    command;
	logic [COORD_W-1:0]  row;
	logic [COORD_W-1:0]  col;
	logic [PIX_W-1:0]    pixel;
	logic [SIZE_W-1:0]   a_width;
	logic [SIZE_W-1:0]   a_height;
	logic [SIZE_W-1:0]   b_width;
	logic [SIZE_W-1:0]   b_height;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    min_mismatch;

	logic [PIX_W-1:0] a_pixels [DEPTH];
	logic [PIX_W-1:0] b_pixels [DEPTH];
	logic [PIX_W-1:0] cfg_background;
	logic [PB_W-1:0]  cfg_pixel_bytes;

	verdict_t expected_verdicts [$];
	verdict_t got_verdict;
	int       fail_count;
	int       cycle_count;
	int       items_sent;
	bit       no_gaps;

	template_mismatch_search_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.row          (row),
		.col          (col),
		.pixel        (pixel),
		.a_width      (a_width),
		.a_height     (a_height),
		.b_width      (b_width),
		.b_height     (b_height),
		.done         (done),
		.status       (status),
		.min_mismatch (min_mismatch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("MISMATCH: %s", msg);
	endtask

	function automatic verdict_t predict_min_mismatch(input logic [SIZE_W-1:0] aw,
			input logic [SIZE_W-1:0] ah, input logic [SIZE_W-1:0] bw,
			input logic [SIZE_W-1:0] bh);
		verdict_t         v;
		logic             b_outer;
		int               ow, oh, iw, ih, dx, dy, cols, rows, best, n;
		logic [PIX_W-1:0] mask, bkg, po, pi;
		v.st = STATUS_OK;
		v.cnt = '0;
		if (aw > MAX_WIDTH || bw > MAX_WIDTH || ah > MAX_HEIGHT || bh > MAX_HEIGHT) begin
			v.st = STATUS_SHAPE;
			return v;
		end
		if ((aw > bw && ah < bh) || (aw < bw && ah > bh)) begin
			v.st = STATUS_SHAPE;
			return v;
		end
		b_outer = (aw < bw) && (ah < bh);
		ow = b_outer ? int'(bw) : int'(aw);
		oh = b_outer ? int'(bh) : int'(ah);
		iw = b_outer ? int'(aw) : int'(bw);
		ih = b_outer ? int'(ah) : int'(bh);
		dx = (ow > iw) ? ow - iw : 0;
		dy = (oh > ih) ? oh - ih : 0;
		if (dx > MAX_SHIFT || dy > MAX_SHIFT) begin
			v.st = STATUS_SHAPE;
			return v;
		end
		if (cfg_pixel_bytes == PB_RGB) begin
			mask = MASK_24;
		end else if (cfg_pixel_bytes == PB_RGBA) begin
			mask = MASK_32;
		end else begin
			v.st = STATUS_PIXEL;
			return v;
		end
		if (ih == 0) begin
			v.st = STATUS_SHAPE;
			return v;
		end
		bkg = cfg_background & mask;
		cols = (iw < ow) ? iw : ow;
		rows = (ih < oh) ? ih : oh;
		best = -1;
		for (int y = 0; y <= dy; y++) begin
			for (int x = 0; x <= dx; x++) begin
				n = 0;
				for (int r = 0; r < rows; r++) begin
					for (int c = 0; c < cols; c++) begin
						po = b_outer ? b_pixels[((y + r) * MAX_WIDTH + x + c) % DEPTH]
						             : a_pixels[((y + r) * MAX_WIDTH + x + c) % DEPTH];
						pi = b_outer ? a_pixels[(r * MAX_WIDTH + c) % DEPTH]
						             : b_pixels[(r * MAX_WIDTH + c) % DEPTH];
						po &= mask;
						pi &= mask;
						if (po != pi && (po == bkg || pi == bkg))
							n++;
					end
				end
				if (best < 0 || n < best)
					best = n;
			end
		end
		v.cnt = CNT_W'(best);
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 5))
			0, 1: return cfg_background;
			2: return cfg_background ^ 32'hFF00_0000;
			3: return 32'h00A0_B0C0;
			4: return cfg_background ^ (32'h1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input work_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    <= 1'b1;
		command  <= it.cmd;
		row      <= it.row;
		col      <= it.col;
		pixel    <= it.pixel;
		a_width  <= it.aw;
		a_height <= it.ah;
		b_width  <= it.bw;
		b_height <= it.bh;
		do @(posedge clk); while (busy);
		items_sent++;
		case (it.cmd)
			CMD_LOAD_A: a_pixels[{it.row, it.col}] = it.pixel;
			CMD_LOAD_B: b_pixels[{it.row, it.col}] = it.pixel;
			CMD_COMPARE: expected_verdicts.push_back(predict_min_mismatch(it.aw, it.ah,
				it.bw, it.bh));
			default: ;
		endcase
	endtask

	task automatic issue_load(input cmd_t which, input int r, input int c,
			input logic [PIX_W-1:0] pix);
		work_item_t it;
		it.cmd = which;
		it.row = COORD_W'(r);
		it.col = COORD_W'(c);
		it.pixel = pix;
		it.aw = SIZE_W'($urandom);
		it.ah = SIZE_W'($urandom);
		it.bw = SIZE_W'($urandom);
		it.bh = SIZE_W'($urandom);
		send_item(it);
	endtask

	task automatic issue_compare(input int aw, input int ah, input int bw, input int bh);
		work_item_t it;
		it.cmd = CMD_COMPARE;
		it.row = COORD_W'($urandom);
		it.col = COORD_W'($urandom);
		it.pixel = $urandom;
		it.aw = SIZE_W'(aw);
		it.ah = SIZE_W'(ah);
		it.bw = SIZE_W'(bw);
		it.bh = SIZE_W'(bh);
		send_item(it);
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_register(input logic index);
		logic [PDATA_W-1:0] readback, want, keep;
		keep = (index == REG_BACKGROUND) ? MASK_32 : 32'h7;
		want = (index == REG_BACKGROUND) ? cfg_background : 32'(cfg_pixel_bytes);
		apb_transfer(1'b0, {index, 2'b00}, '0, readback);
		if ((readback & keep) !== want)
			note_failure($sformatf("register %0d read: expected %h, got %h", index, want,
				readback & keep));
	endtask

	task automatic write_register(input logic index, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] unused;
		apb_transfer(1'b1, {index, 2'b00}, value, unused);
		if (index == REG_BACKGROUND)
			cfg_background = value;
		else
			cfg_pixel_bytes = value[PB_W-1:0];
		check_register(index);
	endtask

	task automatic test_register_reset();
		check_register(REG_BACKGROUND);
		check_register(REG_PIXEL_BYTES);
	endtask

	task automatic test_rejects_before_load();
		work_item_t it;
		issue_compare(10, 5, 5, 10);
		issue_compare(33, 4, 4, 4);
		issue_compare(63, 63, 63, 63);
		issue_compare(4, 4, 4, 0);
		issue_compare(0, 0, 0, 0);
		issue_compare(10, 10, 5, 10);
		issue_compare(2, 2, 9, 9);
		it.cmd = CMD_NONE;
		it.row = '1;
		it.col = '1;
		it.pixel = '1;
		it.aw = 6'd4;
		it.ah = 6'd4;
		it.bw = 6'd4;
		it.bh = 6'd4;
		send_item(it);
	endtask

	task automatic test_full_frame();
		for (int r = 0; r < FRAME_SIZE; r++) begin
			no_gaps = (r % 2 == 1);
			for (int c = 0; c < FRAME_SIZE; c++) begin
				issue_load(CMD_LOAD_A, r, c, cfg_background);
				issue_load(CMD_LOAD_B, r, c, 32'h0012_3456);
			end
		end
		no_gaps = 1'b0;
		issue_compare(FRAME_SIZE, FRAME_SIZE, FRAME_SIZE, FRAME_SIZE);
		issue_compare(FRAME_SIZE, FRAME_SIZE, FRAME_SIZE - MAX_SHIFT, FRAME_SIZE - MAX_SHIFT);
		issue_compare(FRAME_SIZE - MAX_SHIFT, FRAME_SIZE - MAX_SHIFT, FRAME_SIZE, FRAME_SIZE);
	endtask

	task automatic test_pixel_size();
		settle();
		issue_load(CMD_LOAD_A, 0, 0, 32'h00FF_FFFF);
		issue_load(CMD_LOAD_B, 0, 0, 32'hFFFF_FFFF);
		issue_compare(1, 1, 1, 1);
		settle();
		write_register(REG_PIXEL_BYTES, 32'(PB_RGB));
		issue_compare(1, 1, 1, 1);
		for (int v = 0; v < 8; v++) begin
			if (v != PB_RGB && v != PB_RGBA) begin
				settle();
				write_register(REG_PIXEL_BYTES, 32'(v));
				issue_compare(2, 2, 2, 2);
			end
		end
		issue_compare(6, 2, 2, 6);
		issue_compare(2, 2, 2, 0);
		settle();
		write_register(REG_PIXEL_BYTES, 32'(PB_RGBA));
	endtask

	task automatic test_special_shapes();
		issue_compare(1, 1, 1, 1);
		issue_compare(4, 4, 0, 4);
		issue_compare(8, 5, 8, 7);
		issue_compare(5, 6, 7, 6);
		issue_compare(3, 3, 6, 6);
		issue_compare(FRAME_SIZE, FRAME_SIZE, FRAME_SIZE, FRAME_SIZE - MAX_SHIFT);
	endtask

	task automatic random_sequence();
		work_item_t it;
		int         pick, ow, oh, dx, dy, w, h;
		bit         a_outer;
		pick = $urandom_range(0, 99);
		no_gaps = ($urandom_range(0, 3) == 0);
		if (pick < 10) begin
			repeat ($urandom_range(1, 4)) begin
				it.cmd = cmd_t'($urandom_range(0, 3));
				it.row = COORD_W'($urandom);
				it.col = COORD_W'($urandom);
				it.pixel = pick_pixel();
				it.aw = SIZE_W'($urandom_range(0, FRAME_SIZE));
				it.ah = SIZE_W'($urandom_range(0, FRAME_SIZE));
				it.bw = SIZE_W'($urandom_range(0, FRAME_SIZE));
				it.bh = SIZE_W'($urandom_range(0, FRAME_SIZE));
				send_item(it);
			end
		end else if (pick < 25) begin
			w = $urandom_range(2, 8);
			h = $urandom_range(6, 32);
			case ($urandom_range(0, 3))
				0: issue_compare(w, w - 1, w - 1, w);
				1: begin
					dx = $urandom_range(5, h);
					if ($urandom_range(0, 1))
						issue_compare(h, h, h - dx, h);
					else
						issue_compare(h - dx, h - dx, h, h);
				end
				2: issue_compare($urandom_range(33, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63));
				default: issue_compare(w, $urandom_range(0, 4), w, 0);
			endcase
		end else begin
			ow = ($urandom_range(0, 19) == 0) ? $urandom_range(12, FRAME_SIZE)
				: $urandom_range(1, 10);
			oh = ($urandom_range(0, 19) == 0) ? $urandom_range(12, FRAME_SIZE)
				: $urandom_range(1, 10);
			dx = $urandom_range(0, (ow - 1 < MAX_SHIFT) ? ow - 1 : MAX_SHIFT);
			dy = $urandom_range(0, (oh - 1 < MAX_SHIFT) ? oh - 1 : MAX_SHIFT);
			a_outer = $urandom_range(0, 1);
			repeat ($urandom_range(3, 20))
				issue_load($urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B,
					$urandom_range(0, oh - 1), $urandom_range(0, ow - 1), pick_pixel());
			if (a_outer)
				issue_compare(ow, oh, ow - dx, oh - dy);
			else
				issue_compare(ow - dx, oh - dy, ow, oh);
		end
	endtask

	task automatic test_random_traffic();
		logic [PDATA_W-1:0] bkg;
		logic [PB_W-1:0]    pb;
		int                 phase_start;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			case (p % 4)
				0: bkg = MASK_32;
				1: bkg = '0;
				2: bkg = $urandom;
				default: bkg = 32'hFF00_0000 | $urandom_range(0, 255);
			endcase
			if (p == 5)
				pb = $urandom_range(0, 1) ? PB_W'($urandom_range(5, 7)) : PB_W'($urandom_range(0, 2));
			else
				pb = (p % 2 == 0) ? PB_RGBA : PB_RGB;
			write_register(REG_BACKGROUND, bkg);
			write_register(REG_PIXEL_BYTES, 32'(pb));
			phase_start = items_sent;
			while (items_sent - phase_start < RANDOM_ITEMS / RANDOM_PHASES)
				random_sequence();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_verdicts.size() == 0) begin
				note_failure($sformatf("unexpected result status=%0d min_mismatch=%0d", status,
					min_mismatch));
			end else begin
				got_verdict = expected_verdicts.pop_front();
				if (status !== got_verdict.st || min_mismatch !== got_verdict.cnt)
					note_failure($sformatf("status expected %0d got %0d, min_mismatch expected %0d got %0d",
						got_verdict.st, status, got_verdict.cnt, min_mismatch));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_template_mismatch_search_top NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		start    = 1'b0;
		command  = CMD_NONE;
		row      = '0;
		col      = '0;
		pixel    = '0;
		a_width  = '0;
		a_height = '0;
		b_width  = '0;
		b_height = '0;
		cfg_background  = BKG_RESET;
		cfg_pixel_bytes = PB_RGBA;
		fail_count  = 0;
		cycle_count = 0;
		items_sent  = 0;
		no_gaps     = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_rejects_before_load();
		test_full_frame();
		test_pixel_size();
		test_special_shapes();
		test_random_traffic();

		settle();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_template_mismatch_search_top OK");
		else
			$display("tb_template_mismatch_search_top NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/tms_pkg.sv
hw/rtl/template_mismatch_search_top.sv
tb/sv/tb_template_mismatch_search_top.sv
